FILE: design/vde_pkg.sv
package vde_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int VALUE_W = 32;
	localparam int IDX_W = 8;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      start_req;
	} vde_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             is_new;
		logic             overflow;
	} vde_out_t;

	// search token that walks the cell chain
	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
		logic               found;
		logic [IDX_W-1:0]   slot;
	} vde_probe_t;

endpackage

FILE: design/value_dictionary_encoder.sv
// a request passes the launch register, the cell chain and the done register before its
// response is registered; the search token walks one cell per cycle
// through the full chain of TABLE_DEPTH cells, and the next request enters after the insert
// a new request is taken while the previous response still waits in the output register
// reset clears the fill count and all control state; dictionary cells hold no reset value
module value_dictionary_encoder #(
	parameter int TABLE_DEPTH = vde_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  vde_pkg::vde_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output vde_pkg::vde_out_t rsp
);
	import vde_pkg::*;

	localparam int FW = $clog2(TABLE_DEPTH + 1);

	logic             busy_q;
	logic [FW-1:0]    fill_q;
	vde_probe_t       launch_q;
	vde_probe_t       done_q;
	vde_probe_t       chain [TABLE_DEPTH];
	logic [TABLE_DEPTH:0] token_v;
	logic             rsp_valid_q;
	vde_out_t         rsp_q;
	vde_out_t         rsp_d;
	logic             accept;
	logic             move;
	logic             room;
	logic             ins_en;

	assign req_stall = busy_q;
	assign accept    = req_valid && !req_stall;
	assign room      = fill_q < FW'(TABLE_DEPTH);
	assign move      = done_q.valid && (!rsp_valid_q || !rsp_stall);
	assign ins_en    = move && !done_q.found && room;

	always_comb begin
		rsp_d = '0;
		if (done_q.found) begin
			rsp_d.index = done_q.slot;
		end else if (room) begin
			rsp_d.index  = IDX_W'(fill_q);
			rsp_d.is_new = 1'b1;
		end else begin
			rsp_d.overflow = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fill_q      <= '0;
			launch_q    <= '0;
			done_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			launch_q.valid <= accept;
			if (accept) begin
				launch_q.value <= req.value;
				launch_q.found <= 1'b0;
				launch_q.slot  <= '0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				if (req.start_req) begin
					fill_q <= '0;
				end
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (ins_en) begin
				fill_q <= fill_q + FW'(1);
			end
			if (chain[TABLE_DEPTH-1].valid) begin
				done_q.valid <= 1'b1;
				done_q.value <= chain[TABLE_DEPTH-1].value;
				done_q.found <= chain[TABLE_DEPTH-1].found;
				done_q.slot  <= chain[TABLE_DEPTH-1].slot;
			end else if (move) begin
				done_q.valid <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rsp_q <= rsp_d;
		end
	end

	assign token_v[0] = launch_q.valid;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		vde_probe_t probe_in;
		if (k == 0) begin : g_head
			assign probe_in = launch_q;
		end else begin : g_link
			assign probe_in = chain[k-1];
		end
		vde_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.IDX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.probe_in(probe_in),
			.probe_out(chain[k]),
			.fill(fill_q),
			.wr_en(ins_en),
			.wr_value(done_q.value)
		);
		assign token_v[k+1] = chain[k].valid;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({token_v, done_q.valid}))
		else $error("more than one request in the chain");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(token_v != '0) |-> busy_q)
		else $error("search token without a busy request");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> fill_q == $past(fill_q) + FW'(1))
		else $error("insert did not advance fill count");

	a_overflow_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.overflow) |-> (rsp_q.index == '0 && !rsp_q.is_new))
		else $error("overflow response with index or new flag");

endmodule

FILE: design/vde_cell.sv
module vde_cell #(
	parameter int TABLE_DEPTH = vde_pkg::TABLE_DEPTH_DEF,
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vde_pkg::vde_probe_t                probe_in,
	output vde_pkg::vde_probe_t                probe_out,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   fill,
	input  logic                               wr_en,
	input  logic [vde_pkg::VALUE_W-1:0]        wr_value
);
	import vde_pkg::*;

	localparam int FW = $clog2(TABLE_DEPTH + 1);

	logic [VALUE_W-1:0] data_q;
	vde_probe_t         probe_q;
	logic               live;
	logic               hit;

	// only slots below the fill count take part in the search
	assign live = FW'(IDX) < fill;
	assign hit  = live && (data_q == probe_in.value);

	always_ff @(posedge clk) begin
		if (wr_en && (fill == FW'(IDX))) begin
			data_q <= wr_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.valid <= probe_in.valid;
			probe_q.value <= probe_in.value;
			probe_q.found <= probe_in.found | hit;
			probe_q.slot  <= probe_in.found ? probe_in.slot : IDX_W'(IDX);
		end
	end

	assign probe_out = probe_q;

endmodule
